// ===== src/pli_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, codes and defaults for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int INDEX_W        = 6;
    localparam int PC_W           = 7;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int STATUS_W       = 2;

    localparam logic [PC_W-1:0] POINT_COUNT_RST = 7'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT = 1'b0,
        REG_EXTRAPOLATE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

endpackage
`default_nettype wire

// ===== src/piecewise_linear_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with a sequenced search and a shift-subtract divider.
// ----------------------------------------------------------------------------
// Usage: a load beat (func = 0) writes one breakpoint into the x and y tables
// and gives no result. A query beat (func = 1) gives one result beat with
// the interpolated value and a status code.
// The user must write the configuration (point count, extrapolation) through
// the plain write port while the block is idle; the block does not enforce it.
// A query first compares with the second-to-last breakpoint; at or beyond it
// the last segment is taken, else a search steps from the first breakpoint
// until it stops. Then follow fetch and operand set-up (S_FETCH_L to S_MUL),
// the restoring divider (one quotient bit per cycle) and the sum, saturate
// and register steps (S_ADD, S_OUT). With fewer than two points the query
// goes straight to the output step; a zero-width segment skips the divider.
// in_stall is high from a query until its result is registered, so no new
// beat is taken while a query runs; the search loop, the divider and output
// stalls set the rate.
// Reset clears the sequencer and output valid and restores the configuration;
// table contents are not cleared and must be loaded before they are queried.
// When the receiver stalls, the result beat holds; a finished query waits
// for the output register to free before it retires.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [pli_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pli_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic [pli_pkg::INDEX_W-1:0]         point_index,
    input  wire logic signed [pli_pkg::DATA_W-1:0]   point_x,
    input  wire logic signed [pli_pkg::DATA_W-1:0]   point_y,
    input  wire logic signed [pli_pkg::DATA_W-1:0]   query_x,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [pli_pkg::DATA_W-1:0]        value,
    output logic [pli_pkg::STATUS_W-1:0]             status
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW_MIN = $clog2(MAX_POINTS + 1);
    localparam int CW     = (CW_MIN > pli_pkg::PC_W) ? CW_MIN : pli_pkg::PC_W;
    localparam int DW     = pli_pkg::DATA_W;
    localparam int PW     = 2 * DW;
    localparam int SW     = DW + 4;
    localparam int MW     = DW + 3;
    localparam int KW     = $clog2(PW);

    localparam logic [PW-1:0]        MAG_LIMIT = PW'(64'h4_0000_0000);
    localparam logic signed [SW-1:0] SAT_MAX   = 36'sh0_7FFF_FFFF;
    localparam logic signed [SW-1:0] SAT_MIN   = 36'shF_8000_0000;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_LAST    = 12'b0000_0000_0010,
        S_SCAN    = 12'b0000_0000_0100,
        S_FETCH_L = 12'b0000_0000_1000,
        S_FETCH_R = 12'b0000_0001_0000,
        S_HOLD    = 12'b0000_0010_0000,
        S_DIFF    = 12'b0000_0100_0000,
        S_PREP    = 12'b0000_1000_0000,
        S_MUL     = 12'b0001_0000_0000,
        S_DIV     = 12'b0010_0000_0000,
        S_ADD     = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [KW-1:0]            cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [pli_pkg::PC_W-1:0] point_count_reg, point_count_next;
    logic                     extrap_reg, extrap_next;

    logic [DW-1:0]            x_mem [MAX_POINTS];
    logic [DW-1:0]            y_mem [MAX_POINTS];
    logic [AW-1:0]            rd_addr;
    logic signed [DW-1:0]     x_rd_reg, y_rd_reg;

    logic signed [DW-1:0]     q_reg, xl_reg, xr_reg, yl_reg, yr_reg;
    logic signed [DW:0]       den_reg, dx_reg, dy_reg;
    logic [DW-1:0]            den_mag_reg, dx_mag_reg, dy_mag_reg;
    logic                     neg_reg;
    logic [DW-1:0]            rem_reg;
    logic [PW-1:0]            quo_reg;
    logic signed [SW-1:0]     sum_reg;
    logic [pli_pkg::STATUS_W-1:0] status_reg, status_out_reg;
    logic signed [DW-1:0]     value_reg;

    logic                     in_fire, load_fire, query_fire, out_load;
    logic [CW-1:0]            count_ext, n_pts, n_m2;
    logic                     too_few;
    logic signed [DW-1:0]     yl_hold, yr_hold;
    logic [DW:0]              rem_shift, rem_sub;
    logic                     q_bit;
    logic [PW-1:0]            prod;
    logic [MW-1:0]            mag_clamped;
    logic signed [SW-1:0]     yl_ext, mag_ext;
    logic signed [DW-1:0]     sat_value;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign load_fire  = in_fire && (func == pli_pkg::FUNC_LOAD);
    assign query_fire = in_fire && (func == pli_pkg::FUNC_QUERY);
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    assign count_ext = CW'(point_count_reg);
    assign n_pts     = (count_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_ext;
    assign n_m2      = n_pts - CW'(2);
    assign too_few   = (n_pts < CW'(2));

    assign yr_hold = (!extrap_reg && (q_reg < xl_reg)) ? yl_reg : yr_reg;
    assign yl_hold = (!extrap_reg && (q_reg > xr_reg)) ? yr_hold : yl_reg;

    assign rem_shift = {rem_reg, quo_reg[PW-1]};
    assign q_bit     = (rem_shift >= {1'b0, den_mag_reg});
    assign rem_sub   = q_bit ? (rem_shift - {1'b0, den_mag_reg}) : rem_shift;

    assign prod = PW'(dy_mag_reg) * PW'(dx_mag_reg);

    assign mag_clamped = (quo_reg > MAG_LIMIT) ? MW'(MAG_LIMIT) : quo_reg[MW-1:0];
    assign yl_ext      = SW'(yl_reg);
    assign mag_ext     = signed'({1'b0, mag_clamped});

    assign sat_value = (sum_reg > SAT_MAX) ? DW'(SAT_MAX) :
                       (sum_reg < SAT_MIN) ? DW'(SAT_MIN) : sum_reg[DW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        rd_addr          = AW'(idx_reg + AW'(1));
        out_valid_next   = out_valid_reg && out_stall;
        point_count_next = point_count_reg;
        extrap_next      = extrap_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                pli_pkg::REG_POINT_COUNT: point_count_next = cfg_data[pli_pkg::PC_W-1:0];
                pli_pkg::REG_EXTRAPOLATE: extrap_next      = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = AW'(n_m2);
                if (query_fire)
                begin
                    state_next = too_few ? S_OUT : S_LAST;
                end
            end
            S_LAST:
            begin
                if (q_reg >= x_rd_reg)
                begin
                    idx_next   = AW'(n_m2);
                    rd_addr    = AW'(n_m2);
                    state_next = S_FETCH_L;
                end
                else
                begin
                    idx_next   = '0;
                    rd_addr    = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((CW'(idx_reg) < n_m2) && (q_reg > x_rd_reg))
                begin
                    idx_next = AW'(idx_reg + AW'(1));
                    rd_addr  = AW'(idx_reg + AW'(2));
                end
                else
                begin
                    rd_addr    = idx_reg;
                    state_next = S_FETCH_L;
                end
            end
            S_FETCH_L:
            begin
                rd_addr    = AW'(idx_reg + AW'(1));
                state_next = S_FETCH_R;
            end
            S_FETCH_R: state_next = S_HOLD;
            S_HOLD:    state_next = S_DIFF;
            S_DIFF:    state_next = S_PREP;
            S_PREP:    state_next = (den_reg == '0) ? S_OUT : S_MUL;
            S_MUL:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = KW'(cnt_reg + KW'(1));
                if (cnt_reg == KW'(PW - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            point_count_reg <= pli_pkg::POINT_COUNT_RST;
            extrap_reg      <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            point_count_reg <= point_count_next;
            extrap_reg      <= extrap_next;
        end
    end

    // breakpoint tables
    always_ff @(posedge clk)
    begin
        if (load_fire && (int'(point_index) < MAX_POINTS))
        begin
            x_mem[AW'(point_index)] <= point_x;
            y_mem[AW'(point_index)] <= point_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (query_fire)
                begin
                    q_reg      <= query_x;
                    status_reg <= too_few ? pli_pkg::ST_FEW : pli_pkg::ST_OK;
                end
            end
            S_FETCH_L:
            begin
                xl_reg <= x_rd_reg;
                yl_reg <= y_rd_reg;
            end
            S_FETCH_R:
            begin
                xr_reg <= x_rd_reg;
                yr_reg <= y_rd_reg;
            end
            S_HOLD:
            begin
                yl_reg <= yl_hold;
                yr_reg <= yr_hold;
            end
            S_DIFF:
            begin
                den_reg <= (DW+1)'(xr_reg) - (DW+1)'(xl_reg);
                dx_reg  <= (DW+1)'(q_reg) - (DW+1)'(xl_reg);
                dy_reg  <= (DW+1)'(yr_reg) - (DW+1)'(yl_reg);
            end
            S_PREP:
            begin
                den_mag_reg <= den_reg[DW] ? DW'(-den_reg) : den_reg[DW-1:0];
                dx_mag_reg  <= dx_reg[DW]  ? DW'(-dx_reg)  : dx_reg[DW-1:0];
                dy_mag_reg  <= dy_reg[DW]  ? DW'(-dy_reg)  : dy_reg[DW-1:0];
                neg_reg     <= dy_reg[DW] ^ dx_reg[DW] ^ den_reg[DW];
                if (den_reg == '0)
                begin
                    status_reg <= pli_pkg::ST_ZERO;
                end
            end
            S_MUL:
            begin
                quo_reg <= prod;
                rem_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= rem_sub[DW-1:0];
                quo_reg <= {quo_reg[PW-2:0], q_bit};
            end
            S_ADD:
            begin
                sum_reg <= neg_reg ? (yl_ext - mag_ext) : (yl_ext + mag_ext);
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    value_reg      <= (status_reg == pli_pkg::ST_OK) ? sat_value : '0;
                    status_out_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_out_reg;

`ifndef SYNTHESIS
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> in_stall)
        else $error("query beat did not block the input");

    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output step");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_mag_reg))
        else $error("divider remainder not below divisor");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != pli_pkg::ST_OK)) |-> (value == '0))
        else $error("error result carries a non-zero value");
`endif

endmodule
`default_nettype wire
